FILE: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared constants and types for the timer table block.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int unsigned SLOTS_DEF = 16;
	localparam logic [31:0] PEND_MAX = 32'hffff_ffff;

	typedef enum logic [2:0] {
		MODE_TICK    = 3'd0,
		MODE_SERVICE = 3'd1,
		MODE_SET     = 3'd2,
		MODE_CANCEL  = 3'd3,
		MODE_UPDATE  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED = 2'd0,
		KIND_SET     = 2'd1,
		KIND_DONE    = 2'd2
	} kind_t;

endpackage

FILE: src/ptt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/ptt_mod.sv
// ----------------------------------------------------------------------------
// Sequential modulo unit
// Computes a mod b for 32-bit unsigned values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptt_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] rem
);
	logic [32:0] r_q;
	logic [31:0] n_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {r_q[31:0], n_q[31]};
	assign diff = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			n_q <= num;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[30:0], 1'b0};
			r_q <= diff[32] ? shifted : diff;
		end
	end

	assign rem = r_q[31:0];
endmodule

FILE: src/periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// Table of periodic timer slots driven by tick, service, set, cancel, update.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis; results leave on m_axis, the last result of
// each input beat carrying tlast. A cfg write sets service_on_request and is
// made only while the block is idle.
// Set scans the active flags one slot per cycle for the first free slot. A
// service visits the slots in order through the slot memories; an expiring
// slot that reloads also runs the bit-serial modulo. One item is processed at
// a time.
// Each result is held in an output register until taken; while the receiver
// stalls the walk waits, so nothing is lost. Reset clears all active flags,
// the pending count and the register; the slot memories need no clearing.
// ----------------------------------------------------------------------------
module periodic_timer_table_top #(
	parameter int unsigned SLOTS = ptt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0], slot[6:3], interval[38:7], repeat_count[70:39], zero fill
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind[1:0], slot_index[5:2], full_res[6], zero fill
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);
	import ptt_pkg::*;

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned RD = 1 << AW;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DEC   = 8'b0000_0010,
		ST_RD    = 8'b0000_0100,
		ST_EVAL  = 8'b0000_1000,
		ST_MOD   = 8'b0001_0000,
		ST_WB    = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_SCAN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic sor_q;
	logic [31:0] pend_q;
	logic [31:0] d_q;
	logic [RD-1:0] act_q;
	logic [2:0] mode_q;
	logic [3:0] slot_q;
	logic [AW-1:0] slot_ix;
	logic [31:0] ivl_q;
	logic [31:0] rep_q;
	logic [AW:0] idx_q;
	logic [AW-1:0] ix;
	logic out_last_q;
	logic [1:0] out_kind_q;
	logic [3:0] out_idx_q;
	logic out_full_q;
	logic out_pend_q;
	logic out_load;
	logic svc_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] w_rem, w_ivl, w_rep;
	logic [31:0] r_rem, r_ivl, r_rep;
	logic [31:0] new_rem_q;
	logic [31:0] new_rep_q;
	logic reload_q;

	logic mod_start, mod_done;
	logic [31:0] mod_rem;
	logic slot_ok;

	assign ix = idx_q[AW-1:0];
	assign slot_ix = AW'(slot_q);
	assign slot_ok = ({28'd0, slot_q} < 32'(SLOTS));
	assign out_load = ((state_q == ST_EVAL && act_q[ix] && !(r_rem > d_q)) ||
		state_q == ST_OUT) && (!out_pend_q || m_axis_tready);

	ptt_ram #(.WIDTH(32), .DEPTH(RD)) u_rem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_rem), .raddr(ix), .rdata(r_rem));
	ptt_ram #(.WIDTH(32), .DEPTH(RD)) u_ivl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_ivl), .raddr(ix), .rdata(r_ivl));
	ptt_ram #(.WIDTH(32), .DEPTH(RD)) u_rep (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_rep), .raddr(ix), .rdata(r_rep));

	ptt_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.num(d_q - r_rem), .den(r_ivl), .done(mod_done), .rem(mod_rem));

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_pend_q;
	assign m_axis_tdata = {1'b0, out_full_q, out_idx_q, out_kind_q};
	assign m_axis_tlast = out_last_q;

	always_comb begin
		we = 1'b0;
		waddr = ix;
		w_rem = new_rem_q;
		w_ivl = r_ivl;
		w_rep = new_rep_q;
		mod_start = 1'b0;
		if (state_q == ST_DEC && (mode_q == MODE_UPDATE) && slot_ok) begin
			waddr = slot_ix;
			we = act_q[slot_ix] && (SLOTS >= 16 || 32'(slot_q) < 32'(SLOTS));
			w_rem = ivl_q;
			w_ivl = ivl_q;
			w_rep = rep_q;
		end else if (state_q == ST_SCAN && !act_q[ix] && idx_q < (AW+1)'(SLOTS)) begin
			we = 1'b1;
			w_rem = ivl_q;
			w_ivl = ivl_q;
			w_rep = rep_q;
		end else if (state_q == ST_WB) begin
			we = 1'b1;
			w_rem = reload_q ? ((r_ivl == 32'd0) ? 32'd0 : r_ivl - mod_rem) : new_rem_q;
		end
		if (state_q == ST_EVAL && act_q[ix] && !(r_rem > d_q) &&
			!(r_rep == 32'd1) && r_ivl != 32'd0) begin
			mod_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sor_q <= 1'b0;
			pend_q <= '0;
			act_q <= '0;
			out_pend_q <= 1'b0;
			idx_q <= '0;
			svc_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_pend_q <= 1'b1;
			end else if (out_pend_q && m_axis_tready) begin
				out_pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						sor_q <= cfg_data;
					end
					if (s_axis_tvalid) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					idx_q <= '0;
					svc_q <= 1'b0;
					case (mode_q)
						MODE_TICK: begin
							if (sor_q) begin
								if (pend_q != PEND_MAX) pend_q <= pend_q + 32'd1;
								state_q <= ST_OUT;
							end else begin
								d_q <= (pend_q != PEND_MAX) ? pend_q + 32'd1 : pend_q;
								pend_q <= '0;
								svc_q <= 1'b1;
								state_q <= ST_RD;
							end
						end
						MODE_SERVICE: begin
							d_q <= pend_q;
							pend_q <= '0;
							svc_q <= 1'b1;
							state_q <= ST_RD;
						end
						MODE_SET: state_q <= ST_SCAN;
						MODE_CANCEL: begin
							if (slot_ok) act_q[slot_ix] <= 1'b0;
							state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_SCAN: begin
					if (idx_q >= (AW+1)'(SLOTS)) begin
						state_q <= ST_OUT;
					end else if (!act_q[ix]) begin
						act_q[ix] <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RD: begin
					if (idx_q >= (AW+1)'(SLOTS)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!act_q[ix]) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end else if (r_rem > d_q) begin
						new_rem_q <= r_rem - d_q;
						new_rep_q <= r_rep;
						reload_q <= 1'b0;
						state_q <= ST_WB;
					end else if (!out_pend_q || m_axis_tready) begin
						new_rep_q <= (r_rep != 32'd0) ? r_rep - 32'd1 : r_rep;
						reload_q <= 1'b1;
						if (r_rep == 32'd1) begin
							act_q[ix] <= 1'b0;
							idx_q <= idx_q + 1'b1;
							state_q <= ST_RD;
						end else if (r_ivl == 32'd0) begin
							state_q <= ST_WB;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) state_q <= ST_WB;
				end
				ST_WB: begin
					idx_q <= idx_q + 1'b1;
					state_q <= ST_RD;
				end
				ST_OUT: begin
					if (!out_pend_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			mode_q <= s_axis_tdata[2:0];
			slot_q <= s_axis_tdata[6:3];
			ivl_q <= s_axis_tdata[38:7];
			rep_q <= s_axis_tdata[70:39];
		end
		if (state_q == ST_EVAL && act_q[ix] && !(r_rem > d_q) &&
			(!out_pend_q || m_axis_tready)) begin
			out_kind_q <= KIND_EXPIRED;
			out_idx_q <= 4'(ix);
			out_full_q <= 1'b0;
			out_last_q <= 1'b0;
		end
		if (state_q == ST_OUT && (!out_pend_q || m_axis_tready)) begin
			out_last_q <= 1'b1;
			if (mode_q == MODE_SET && !svc_q) begin
				out_kind_q <= KIND_SET;
				out_full_q <= (idx_q >= (AW+1)'(SLOTS));
				out_idx_q <= (idx_q >= (AW+1)'(SLOTS)) ? 4'd0 : 4'(ix);
			end else begin
				out_kind_q <= KIND_DONE;
				out_full_q <= 1'b0;
				out_idx_q <= 4'd0;
			end
		end
	end
endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives tick, service, set, cancel and update beats through the input stream
// and the service_on_request register, predicts every result beat with a
// shadow copy of the slot table, and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb;
	import ptt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int SETTLE = 40 * NSLOT + 100;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  slot;
		logic [31:0] interval;
		logic [31:0] repeat_count;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] slot_index;
		logic       full_res;
		logic       last;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	periodic_timer_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	cmd_t   cmd_q[$];
	reply_t reply_q[$];
	int     pushed = 0;
	int     taken = 0;
	int     errors = 0;

	// Shadow copy of the timer table.
	logic        sh_on_request;
	logic        sh_active[NSLOT];
	logic [31:0] sh_remain[NSLOT];
	logic [31:0] sh_reload[NSLOT];
	logic [31:0] sh_repeats[NSLOT];
	logic [31:0] sh_pending;

	function automatic reply_t mk(kind_t k, int idx, logic full, logic last);
		reply_t r;
		r.kind = k;
		r.slot_index = idx[3:0];
		r.full_res = full;
		r.last = last;
		return r;
	endfunction

	task automatic service_table();
		logic [31:0] d;
		d = sh_pending;
		sh_pending = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (!sh_active[i]) continue;
			if (sh_remain[i] > d) begin
				sh_remain[i] = sh_remain[i] - d;
				continue;
			end
			reply_q.push_back(mk(KIND_EXPIRED, i, 1'b0, 1'b0));
			if (sh_repeats[i] != 0) begin
				sh_repeats[i] = sh_repeats[i] - 1;
				if (sh_repeats[i] == 0) begin
					sh_active[i] = 1'b0;
					continue;
				end
			end
			if (sh_reload[i] == 0)
				sh_remain[i] = '0;
			else
				sh_remain[i] = sh_reload[i] - ((d - sh_remain[i]) % sh_reload[i]);
		end
	endtask

	task automatic table_step(cmd_t c);
		int found;
		found = -1;
		case (c.mode)
			MODE_TICK: begin
				if (sh_pending != PEND_MAX) sh_pending = sh_pending + 1;
				if (!sh_on_request) service_table();
			end
			MODE_SERVICE: service_table();
			MODE_SET: begin
				for (int i = 0; i < NSLOT; i++)
					if (!sh_active[i] && found < 0) found = i;
				if (found >= 0) begin
					sh_active[found] = 1'b1;
					sh_repeats[found] = c.repeat_count;
					sh_remain[found] = c.interval;
					sh_reload[found] = c.interval;
					reply_q.push_back(mk(KIND_SET, found, 1'b0, 1'b1));
				end else begin
					reply_q.push_back(mk(KIND_SET, 0, 1'b1, 1'b1));
				end
				return;
			end
			MODE_CANCEL: sh_active[c.slot] = 1'b0;
			MODE_UPDATE: begin
				if (sh_active[c.slot]) begin
					sh_repeats[c.slot] = c.repeat_count;
					sh_remain[c.slot] = c.interval;
					sh_reload[c.slot] = c.interval;
				end
			end
			default: ;
		endcase
		reply_q.push_back(mk(KIND_DONE, 0, 1'b0, 1'b1));
	endtask

	// Input driver: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				table_step(cmd_q.pop_front());
				taken++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, cmd_q[0].repeat_count, cmd_q[0].interval,
						cmd_q[0].slot, cmd_q[0].mode};
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 12);
					end
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output ready pattern, with one long hold-off to back up the input.
	int cyc = 0;
	int hold_left = 0;
	int style = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			cyc++;
			if (taken == 100 && !hold_done) begin
				hold_left = 4000;
				hold_done = 1'b1;
			end
			if (cyc % 64 == 0) style = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 0);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_q.size() == 0) begin
				$display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				want = reply_q.pop_front();
				if (m_axis_tdata[1:0] !== want.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, want.kind,
						m_axis_tdata[1:0]);
					errors++;
				end
				if (m_axis_tdata[5:2] !== want.slot_index) begin
					$display("%0t: slot_index expected %0d actual %0d", $time,
						want.slot_index, m_axis_tdata[5:2]);
					errors++;
				end
				if (m_axis_tdata[6] !== want.full_res) begin
					$display("%0t: full_res expected %b actual %b", $time, want.full_res,
						m_axis_tdata[6]);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: tlast expected %b actual %b", $time, want.last,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic add_cmd(logic [2:0] m, logic [3:0] s, logic [31:0] ivl, logic [31:0] rep);
		cmd_t c;
		c.mode = m;
		c.slot = s;
		c.interval = ivl;
		c.repeat_count = rep;
		cmd_q.push_back(c);
		pushed++;
	endtask

	task automatic wait_idle();
		while (!(taken == pushed && reply_q.size() == 0)) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic v);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sh_on_request = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random(int n);
		int r;
		logic [31:0] ivl;
		logic [31:0] rep;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			ivl = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 20);
			rep = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
			if (r < 35) add_cmd(MODE_TICK, 4'($urandom()), ivl, rep);
			else if (r < 50) add_cmd(MODE_SERVICE, 4'($urandom()), ivl, rep);
			else if (r < 72) add_cmd(MODE_SET, 4'($urandom()), ivl, rep);
			else if (r < 84) add_cmd(MODE_CANCEL, 4'($urandom()), ivl, rep);
			else if (r < 96) add_cmd(MODE_UPDATE, 4'($urandom()), ivl, rep);
			else add_cmd(3'($urandom_range(5, 7)), 4'($urandom()), ivl, rep);
		end
	endtask

	initial begin
		sh_on_request = 1'b0;
		sh_pending = '0;
		for (int i = 0; i < NSLOT; i++) begin
			sh_active[i] = 1'b0;
			sh_remain[i] = '0;
			sh_reload[i] = '0;
			sh_repeats[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_cfg(1'b0);
		add_cmd(MODE_SERVICE, 4'd0, 32'd0, 32'd0);
		add_cmd(MODE_SET, 4'd0, 32'd0, 32'd0);
		add_cmd(MODE_SET, 4'd0, 32'd1, 32'd2);
		add_cmd(MODE_SET, 4'd0, 32'hffff_ffff, 32'hffff_ffff);
		add_cmd(MODE_SERVICE, 4'd0, 32'd0, 32'd0);
		add_cmd(MODE_TICK, 4'd15, 32'd0, 32'd0);
		add_cmd(MODE_TICK, 4'd0, 32'd0, 32'd0);
		add_cmd(MODE_UPDATE, 4'd15, 32'd5, 32'd1);
		add_cmd(MODE_UPDATE, 4'd2, 32'd3, 32'd0);
		add_cmd(MODE_CANCEL, 4'd1, 32'hffff_ffff, 32'hffff_ffff);
		add_cmd(3'd5, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
		add_cmd(3'd6, 4'd7, 32'd0, 32'd0);
		add_cmd(3'd7, 4'd8, 32'hffff_ffff, 32'd0);
		for (int i = 0; i < 14; i++) add_cmd(MODE_SET, 4'd0, 32'd7, 32'd0);
		add_cmd(MODE_SET, 4'd0, 32'd1, 32'd1);
		add_cmd(MODE_TICK, 4'd0, 32'd0, 32'd0);

		write_cfg(1'b1);
		for (int i = 0; i < 10; i++) add_cmd(MODE_TICK, 4'd0, 32'd0, 32'd0);
		add_cmd(MODE_SERVICE, 4'd0, 32'd0, 32'd0);
		for (int i = 0; i < NSLOT; i++) add_cmd(MODE_CANCEL, 4'(i), 32'd0, 32'd0);

		write_cfg(1'b0);
		add_random(92);
		write_cfg(1'b1);
		add_random(92);
		write_cfg(1'b0);
		add_random(92);

		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Verification failed");
		$finish;
	end
endmodule

FILE: periodic_timer_table_top.f
src/ptt_pkg.sv
src/ptt_ram.sv
src/ptt_mod.sv
src/periodic_timer_table_top.sv
sim/tb.sv
